// File: rtl/rod_pkg.sv
// ---------------------------------------------------------------------------
// rod_pkg
// Shared types and constants of the record offset directory.
// ---------------------------------------------------------------------------
package rod_pkg;

	localparam int BLOCK_BYTES  = 4096;
	localparam int ENTRIES      = 64;
	localparam int HEADER_BYTES = 16;
	localparam int IDX_W        = $clog2(ENTRIES);
	localparam int CNT_W        = $clog2(ENTRIES + 1);
	localparam int END_W        = 13;
	localparam int DIFF_W       = END_W + 2;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_RESIZE = 2'd1,
		REQ_CHOP   = 2'd2,
		REQ_FIND   = 2'd3
	} req_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOT_MOD  = 2'd3
	} status_e;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] inum;
		logic [11:0] new_size;
		logic [6:0]  chop_len;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] rec_offset;
		logic [11:0] rec_size;
		logic [63:0] found_inum;
	} rsp_t;

	// Per-cell operation applied to the cells from a start index up to, but not including, an end count.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_ADD   = 2'd1,
		CELL_CHOP  = 2'd2
	} cell_op_e;

	typedef struct packed {
		cell_op_e            op;
		logic [IDX_W-1:0]    lo;
		logic [CNT_W-1:0]    hi;
		logic [END_W-1:0]    fill;
		logic [DIFF_W-1:0]   diff;
		logic [END_W-1:0]    so;
		logic [END_W-1:0]    eo;
	} cell_cmd_t;

endpackage

// File: rtl/record_offset_directory.sv
// ---------------------------------------------------------------------------
// record_offset_directory
// Slot directory of one block of packed variable-size records.
// ---------------------------------------------------------------------------
// A key below base or outside the slot window goes straight to the result
// state. Lookup and a rejected resize or chop read their slot ends and then
// respond; a resize that extends the directory fills the new slots before
// applying the size change; chop and find-empty then walk one slot per cycle
// through the cell read port. One transaction at a time; busy stays high
// until the result strobe. Reset clears slot count, base and control; slot
// ends are undefined until written. The receiver cannot stall.
module record_offset_directory (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [63:0]         cfg_wdata,
	input  logic                start,
	input  rod_pkg::req_t       req,
	output logic                busy,
	output logic                done,
	output rod_pkg::rsp_t       rsp
);

	localparam int IW = rod_pkg::IDX_W;
	localparam int CW = rod_pkg::CNT_W;
	localparam int EW = rod_pkg::END_W;
	localparam int DW = rod_pkg::DIFF_W;

	localparam rod_pkg::cell_cmd_t CMD_IDLE = '{op: rod_pkg::CELL_HOLD, lo: '0, hi: '0,
		fill: '0, diff: '0, so: '0, eo: '0};

	typedef enum logic [3:0] {
		S_IDLE, S_RD_A, S_WT_A, S_RD_B, S_WT_B, S_RD_C, S_EVAL,
		S_WALK, S_TRIM, S_RSP
	} state_t;

	state_t                  state_q;
	logic [63:0]             base_q;
	logic [CW-1:0]           count_q;
	rod_pkg::req_t           req_q;
	logic [CW-1:0]           at_q;
	logic [CW-1:0]           len_q;
	logic [EW-1:0]           end_at_q, end_at1_q, end_cnt_q, end_run_q;
	logic [IW-1:0]           rd_idx_q;
	logic [EW-1:0]           rd_data;
	logic                    cmd_en_q;
	rod_pkg::cell_cmd_t      cmd_q;
	logic [EW-1:0]           prev_q;
	logic                    first_q;
	logic [1:0]              lag_q;
	logic [EW-1:0]           trim_v_q;
	rod_pkg::rsp_t           rsp_q;
	logic                    done_q;

	logic [63:0]             rel;
	logic                    rel_win;
	logic [CW-1:0]           rel_c;
	logic [CW-1:0]           clen_sat;
	logic [CW:0]             at1;
	logic                    grow;
	logic                    fits;
	logic                    chop_mod;
	logic [EW-1:0]           trim_v;
	logic [DW-1:0]           diff_d;
	logic signed [15:0]      free_b, need_b, size_b, ext_b;
	rod_pkg::rsp_t           rsp_early;
	logic                    issue;
	rod_pkg::cell_cmd_t      cmd_d;

	rod_chain u_chain (
		.clk     (clk),
		.cmd_en  (cmd_en_q),
		.cmd     (cmd_q),
		.rd_idx  (rd_idx_q),
		.rd_data (rd_data)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign rel      = req.inum - base_q;
	assign rel_win  = (req.inum >= base_q) && (rel < 64'(rod_pkg::ENTRIES));
	assign rel_c    = CW'(rel);
	assign clen_sat = (req.chop_len > 7'(rod_pkg::ENTRIES)) ? CW'(rod_pkg::ENTRIES)
		: CW'(req.chop_len);
	assign at1      = (CW+1)'(at_q) + (CW+1)'(1);
	assign grow     = (at1 > (CW+1)'(count_q));
	assign fits     = !(free_b < need_b);
	assign chop_mod = (at_q < count_q) && (end_run_q != end_at_q);
	assign trim_v   = ((at_q + len_q) < count_q) ? end_cnt_q - (end_run_q - end_at_q)
		: end_at_q;
	assign diff_d   = DW'($signed(16'(req_q.new_size)) - size_b);

	always_comb begin
		ext_b  = 16'sd0;
		size_b = 16'sd0;
		if (grow)
			ext_b = 16'(2 * (at1 - (CW+1)'(count_q)));
		else
			size_b = $signed(16'(end_at1_q)) - $signed(16'(end_at_q));
		need_b = $signed(16'(req_q.new_size)) - size_b + ext_b;
		free_b = $signed(16'(rod_pkg::BLOCK_BYTES)) - $signed(16'(end_cnt_q))
			- $signed(16'(2 * count_q)) - $signed(16'(rod_pkg::HEADER_BYTES));
	end

	always_comb begin
		rsp_early = '0;
		if (req.inum < base_q) begin
			rsp_early.status = rod_pkg::ST_RANGE;
		end else if (!rel_win) begin
			unique case (rod_pkg::req_e'(req.req_type))
				rod_pkg::REQ_LOOKUP: rsp_early.status = rod_pkg::ST_RANGE;
				rod_pkg::REQ_RESIZE: rsp_early.status = rod_pkg::ST_NO_SPACE;
				rod_pkg::REQ_CHOP:   rsp_early.status = rod_pkg::ST_NOT_MOD;
				rod_pkg::REQ_FIND:   rsp_early.found_inum = req.inum;
			endcase
		end
	end

	always_comb begin
		issue = 1'b0;
		cmd_d = CMD_IDLE;
		if (state_q == S_EVAL && rod_pkg::req_e'(req_q.req_type) == rod_pkg::REQ_RESIZE
			&& fits) begin
			issue      = 1'b1;
			cmd_d.diff = diff_d;
			if (grow) begin
				cmd_d.op   = rod_pkg::CELL_HOLD;
				cmd_d.lo   = IW'(count_q);
				cmd_d.hi   = CW'(at1);
				cmd_d.fill = end_cnt_q;
			end else begin
				cmd_d.op = rod_pkg::CELL_ADD;
				cmd_d.lo = at_q[IW-1:0];
				cmd_d.hi = count_q;
			end
		end else if (state_q == S_EVAL
			&& rod_pkg::req_e'(req_q.req_type) == rod_pkg::REQ_CHOP && chop_mod) begin
			issue    = 1'b1;
			cmd_d.op = rod_pkg::CELL_CHOP;
			cmd_d.lo = at_q[IW-1:0];
			cmd_d.hi = count_q;
			cmd_d.so = end_at_q;
			cmd_d.eo = end_run_q;
		end else if (state_q == S_WALK
			&& rod_pkg::req_e'(req_q.req_type) == rod_pkg::REQ_RESIZE && first_q) begin
			// apply the size change after the extension
			issue      = (cmd_q.diff != '0);
			cmd_d.op   = rod_pkg::CELL_ADD;
			cmd_d.lo   = at_q[IW-1:0];
			cmd_d.hi   = count_q;
			cmd_d.diff = cmd_q.diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			base_q    <= '0;
			count_q   <= '0;
			cmd_en_q  <= 1'b0;
			cmd_q     <= CMD_IDLE;
			done_q    <= 1'b0;
			rsp_q     <= '0;
			req_q     <= '0;
			at_q      <= '0;
			len_q     <= '0;
			end_at_q  <= '0;
			end_at1_q <= '0;
			end_cnt_q <= '0;
			end_run_q <= '0;
			rd_idx_q  <= '0;
			prev_q    <= '0;
			first_q   <= 1'b0;
			lag_q     <= '0;
			trim_v_q  <= '0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			cmd_en_q <= issue;
			if (issue) begin
				cmd_q <= cmd_d;
			end
			done_q <= (state_q == S_RSP);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= req;
						rsp_q    <= rsp_early;
						at_q     <= rel_c;
						len_q    <= (rel_c < count_q && clen_sat > count_q - rel_c)
							? count_q - rel_c : clen_sat;
						rd_idx_q <= IW'(rel_c - CW'(1));
						state_q  <= rel_win ? S_RD_A : S_RSP;
					end
				end
				S_RD_A: begin
					rd_idx_q <= at_q[IW-1:0];
					state_q  <= S_WT_A;
				end
				S_WT_A: begin
					end_at_q <= (at_q == '0 || at_q > count_q) ? '0 : rd_data;
					rd_idx_q <= IW'(count_q - CW'(1));
					state_q  <= S_RD_B;
				end
				S_RD_B: begin
					end_at1_q <= grow ? '0 : rd_data;
					rd_idx_q  <= IW'(at_q + len_q - CW'(1));
					state_q   <= S_WT_B;
				end
				S_WT_B: begin
					end_cnt_q <= (count_q == '0) ? '0 : rd_data;
					state_q   <= S_RD_C;
				end
				S_RD_C: begin
					end_run_q <= (at_q + len_q == '0) ? '0 : rd_data;
					state_q   <= S_EVAL;
				end
				S_EVAL: begin
					unique case (rod_pkg::req_e'(req_q.req_type))
						rod_pkg::REQ_LOOKUP: begin
							if (at_q < count_q) begin
								rsp_q <= '{status: rod_pkg::ST_OK,
									rec_offset: end_at_q[11:0],
									rec_size: 12'(end_at1_q - end_at_q),
									found_inum: 64'd0};
							end
							state_q <= S_RSP;
						end
						rod_pkg::REQ_RESIZE: begin
							if (!fits) begin
								rsp_q.status <= rod_pkg::ST_NO_SPACE;
								state_q      <= S_RSP;
							end else begin
								if (grow) begin
									count_q <= CW'(at1);
								end
								rsp_q <= '{status: rod_pkg::ST_OK,
									rec_offset: grow ? end_cnt_q[11:0] : end_at_q[11:0],
									rec_size: req_q.new_size,
									found_inum: 64'd0};
								first_q <= grow;
								state_q <= S_WALK;
							end
						end
						rod_pkg::REQ_CHOP: begin
							if (!chop_mod) begin
								rsp_q.status <= rod_pkg::ST_NOT_MOD;
								state_q      <= S_RSP;
							end else begin
								trim_v_q <= trim_v;
								lag_q    <= 2'd2;
								state_q  <= S_TRIM;
							end
						end
						rod_pkg::REQ_FIND: begin
							prev_q   <= end_at_q;
							rd_idx_q <= at_q[IW-1:0];
							first_q  <= 1'b1;
							state_q  <= S_WALK;
						end
					endcase
				end
				S_WALK: begin
					if (rod_pkg::req_e'(req_q.req_type) == rod_pkg::REQ_RESIZE) begin
						if (first_q) begin
							first_q <= 1'b0;
						end else begin
							state_q <= S_RSP;
						end
					end else begin
						// find-empty walks one slot per cycle; read data trails the index through the registered read mux
						if (first_q) begin
							first_q  <= 1'b0;
							rd_idx_q <= IW'(at_q + CW'(1));
						end else if (at_q >= count_q || rd_data == prev_q) begin
							rsp_q.found_inum <= base_q + 64'(at_q);
							state_q          <= S_RSP;
						end else begin
							prev_q   <= rd_data;
							at_q     <= at_q + CW'(1);
							rd_idx_q <= IW'(at_q + CW'(2));
						end
					end
				end
				S_TRIM: begin
					// walk down from the top, drop slots equal to the last end
					if (lag_q != '0) begin
						lag_q    <= lag_q - 2'd1;
						rd_idx_q <= (lag_q == 2'd2) ? IW'(count_q - CW'(2))
							: IW'(count_q - CW'(3));
					end else if (count_q > CW'(1) && rd_data == trim_v_q) begin
						count_q  <= count_q - CW'(1);
						rd_idx_q <= IW'(count_q - CW'(4));
					end else begin
						if (count_q == CW'(1) && trim_v_q == '0) begin
							count_q <= '0;
						end
						state_q <= S_RSP;
					end
				end
				S_RSP: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double result");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(rod_pkg::ENTRIES)) else $error("count overflow");

endmodule

// File: rtl/rod_cell.sv
// ---------------------------------------------------------------------------
// rod_cell
// One directory slot end; updates itself from a broadcast command and
// is read through the registered read mux of rod_chain.
// ---------------------------------------------------------------------------
module rod_cell (
	input  logic                              clk,
	input  logic [rod_pkg::IDX_W-1:0]         idx,
	input  logic                              cmd_en,
	input  rod_pkg::cell_cmd_t                cmd,
	output logic [rod_pkg::END_W-1:0]         value
);

	logic [rod_pkg::END_W-1:0] end_q;
	logic [rod_pkg::DIFF_W-1:0] sum;

	assign value = end_q;
	assign sum   = rod_pkg::DIFF_W'(end_q) + cmd.diff;

	always_ff @(posedge clk) begin
		if (cmd_en && idx >= cmd.lo && rod_pkg::CNT_W'(idx) < cmd.hi) begin
			case (cmd.op)
				rod_pkg::CELL_ADD: begin
					end_q <= sum[rod_pkg::END_W-1:0];
				end
				rod_pkg::CELL_CHOP: begin
					end_q <= (end_q >= cmd.eo) ? end_q - (cmd.eo - cmd.so) : cmd.so;
				end
				rod_pkg::CELL_HOLD: begin
					end_q <= cmd.fill;
				end
				default: begin
					end_q <= end_q;
				end
			endcase
		end
	end

endmodule

// File: rtl/rod_chain.sv
// ---------------------------------------------------------------------------
// rod_chain
// Row of slot cells with a registered read mux.
// ---------------------------------------------------------------------------
module rod_chain (
	input  logic                              clk,
	input  logic                              cmd_en,
	input  rod_pkg::cell_cmd_t                cmd,
	input  logic [rod_pkg::IDX_W-1:0]         rd_idx,
	output logic [rod_pkg::END_W-1:0]         rd_data
);

	logic [rod_pkg::END_W-1:0] vals [rod_pkg::ENTRIES];

	for (genvar g = 0; g < rod_pkg::ENTRIES; g++) begin : g_cell
		rod_cell u_cell (
			.clk    (clk),
			.idx    (rod_pkg::IDX_W'(g)),
			.cmd_en (cmd_en),
			.cmd    (cmd),
			.value  (vals[g])
		);
	end

	always_ff @(posedge clk) begin
		rd_data <= vals[rd_idx];
	end

endmodule

// File: tb/record_offset_directory_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// record_offset_directory_test
// Drives lookup, resize, chop and find-empty requests into the record offset
// directory under several base inode settings, predicts every response from
// a private copy of the directory and compares each response field by field.
// ---------------------------------------------------------------------------
module record_offset_directory_test;

	class dir_scoreboard;
		bit [rod_pkg::END_W-1:0] ends [rod_pkg::ENTRIES];
		int                      count;
		bit [63:0]               base;
		rod_pkg::rsp_t           pending [$];
		int                      errors;
		int                      checked;

		function int end_at(int i);
			if (i == 0 || i > count || i > rod_pkg::ENTRIES) return 0;
			return int'(ends[i - 1]);
		endfunction

		function void note(rod_pkg::req_t r);
			rod_pkg::rsp_t e;
			bit [63:0]     rel;
			int            at, len, so, eo, size, extend, need, offset, lim, free_b, nsize;
			e = '0;
			nsize = int'(r.new_size);
			if (r.inum < base) begin
				e.status = rod_pkg::ST_RANGE;
			end else begin
				rel = r.inum - base;
				case (rod_pkg::req_e'(r.req_type))
				rod_pkg::REQ_LOOKUP: begin
					if (rel >= 64'(rod_pkg::ENTRIES)) begin
						e.status = rod_pkg::ST_RANGE;
					end else if (rel < 64'(count)) begin
						at = int'(rel);
						e.rec_offset = 12'(end_at(at));
						e.rec_size = 12'(end_at(at + 1) - end_at(at));
					end
				end
				rod_pkg::REQ_RESIZE: begin
					if (rel >= 64'(rod_pkg::ENTRIES)) begin
						e.status = rod_pkg::ST_NO_SPACE;
					end else begin
						at = int'(rel);
						extend = 0;
						size = 0;
						if (at + 1 > count) begin
							extend = 2 * (at + 1 - count);
							offset = end_at(count);
						end else begin
							offset = end_at(at);
							size = end_at(at + 1) - offset;
						end
						need = nsize - size + extend;
						free_b = rod_pkg::BLOCK_BYTES - end_at(count) - 2 * count
							- rod_pkg::HEADER_BYTES;
						if (free_b < need) begin
							e.status = rod_pkg::ST_NO_SPACE;
						end else begin
							lim = end_at(count);
							while (count < at + 1) begin
								ends[count] = rod_pkg::END_W'(lim);
								count++;
							end
							if (nsize != size)
								for (int i = at; i < count; i++)
									ends[i] = rod_pkg::END_W'(int'(ends[i]) + nsize - size);
							e.rec_offset = 12'(offset);
							e.rec_size = 12'(nsize);
						end
					end
				end
				rod_pkg::REQ_CHOP: begin
					if (rel >= 64'(count)) begin
						e.status = rod_pkg::ST_NOT_MOD;
					end else begin
						at = int'(rel);
						len = (r.chop_len > 7'd64) ? 64 : int'(r.chop_len);
						if (len > count - at) len = count - at;
						so = end_at(at);
						eo = end_at(at + len);
						if (so == eo) begin
							e.status = rod_pkg::ST_NOT_MOD;
						end else begin
							for (int i = at; i < count; i++)
								ends[i] = (int'(ends[i]) >= eo)
									? rod_pkg::END_W'(int'(ends[i]) - (eo - so))
									: rod_pkg::END_W'(so);
							while (count > 1 && ends[count - 1] == ends[count - 2])
								count--;
							if (count == 1 && ends[0] == 0) count = 0;
						end
					end
				end
				default: begin
					if (rel >= 64'(rod_pkg::ENTRIES)) begin
						e.found_inum = r.inum;
					end else begin
						at = int'(rel);
						if (at < count) begin
							offset = end_at(at);
							for (; at < count; at++) begin
								if (offset == int'(ends[at])) break;
								offset = int'(ends[at]);
							end
						end
						e.found_inum = base + 64'(at);
					end
				end
				endcase
			end
			pending.push_back(e);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check(rod_pkg::rsp_t got);
			rod_pkg::rsp_t want;
			if (pending.size() == 0) begin
				report("unexpected response", 64'(got.status), 64'd0);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
			if (got.rec_offset !== want.rec_offset)
				report("rec_offset", 64'(got.rec_offset), 64'(want.rec_offset));
			if (got.rec_size !== want.rec_size)
				report("rec_size", 64'(got.rec_size), 64'(want.rec_size));
			if (got.found_inum !== want.found_inum)
				report("found_inum", got.found_inum, want.found_inum);
		endtask
	endclass

	logic          clk = 0;
	logic          arst_n = 0;
	logic          cfg_we = 0;
	logic [63:0]   cfg_wdata = '0;
	logic          start = 0;
	rod_pkg::req_t req = '0;
	logic          busy;
	logic          done;
	rod_pkg::rsp_t rsp;

	dir_scoreboard sb = new();
	int idle_cycles;
	int sent;
	int phases;

	record_offset_directory i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check(rsp);
			if (done || (start && !busy)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= 3000) begin
				$display("watchdog: no progress for %0d cycles", idle_cycles);
				$display("record_offset_directory_test: done, errors");
				$finish;
			end
		end
	end

	task send(rod_pkg::req_e kind, logic [63:0] inum, logic [11:0] nsize, logic [6:0] clen);
		rod_pkg::req_t r;
		int            gap;
		r.req_type = kind;
		r.inum = inum;
		r.new_size = nsize;
		r.chop_len = clen;
		gap = int'($urandom_range(15));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note(r);
		sent++;
	endtask

	task set_base(logic [63:0] value);
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.base = value;
		phases++;
	endtask

	task random_item(logic [63:0] base);
		int          pick;
		logic [63:0] key;
		logic [11:0] nsize;
		pick = int'($urandom_range(99));
		if (pick < 4) key = {$urandom, $urandom};
		else if (pick < 8) key = base - 64'($urandom_range(1, 5));
		else key = base + 64'($urandom_range(0, 70));
		pick = int'($urandom_range(99));
		nsize = (pick < 15) ? 12'd0 : (pick < 25) ? 12'($urandom)
			: 12'($urandom_range(1, 150));
		pick = int'($urandom_range(99));
		if (pick < 40) send(rod_pkg::REQ_RESIZE, key, nsize, 7'($urandom));
		else if (pick < 60) send(rod_pkg::REQ_LOOKUP, key, 12'($urandom), 7'($urandom));
		else if (pick < 78) send(rod_pkg::REQ_CHOP, key, 12'($urandom),
			($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 4)));
		else send(rod_pkg::REQ_FIND, key, 12'($urandom), 7'($urandom));
	endtask

	initial begin
		logic [63:0] bases [6];
		bases[0] = 64'd0;
		bases[1] = 64'hFFFF_FFFF_FFFF_FFE0;
		bases[2] = {$urandom, $urandom};
		bases[3] = 64'hFFFF_FFFF_FFFF_FFFF;
		bases[4] = 64'd1000;
		bases[5] = {$urandom, $urandom};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(rod_pkg::REQ_LOOKUP, 64'd0, 12'd0, 7'd0);
		send(rod_pkg::REQ_FIND, 64'd0, 12'd0, 7'd0);
		send(rod_pkg::REQ_CHOP, 64'd0, 12'd0, 7'd1);
		send(rod_pkg::REQ_RESIZE, 64'd0, 12'd4080, 7'd0);
		send(rod_pkg::REQ_RESIZE, 64'd0, 12'd100, 7'd0);
		send(rod_pkg::REQ_RESIZE, 64'd63, 12'd0, 7'd0);
		send(rod_pkg::REQ_LOOKUP, 64'd63, 12'd0, 7'd0);
		send(rod_pkg::REQ_LOOKUP, 64'd64, 12'd0, 7'd0);
		send(rod_pkg::REQ_RESIZE, 64'd64, 12'd1, 7'd0);
		send(rod_pkg::REQ_RESIZE, 64'd5, 12'd4095, 7'd0);
		send(rod_pkg::REQ_RESIZE, 64'd7, 12'd40, 7'd0);
		send(rod_pkg::REQ_FIND, 64'd0, 12'd0, 7'd0);
		send(rod_pkg::REQ_FIND, 64'd70, 12'd0, 7'd0);
		send(rod_pkg::REQ_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 7'd0);
		send(rod_pkg::REQ_CHOP, 64'd1, 12'd0, 7'd0);
		send(rod_pkg::REQ_CHOP, 64'd7, 12'd0, 7'd127);
		send(rod_pkg::REQ_LOOKUP, 64'd0, 12'd0, 7'd0);
		send(rod_pkg::REQ_CHOP, 64'd0, 12'd0, 7'd64);
		send(rod_pkg::REQ_LOOKUP, 64'd0, 12'd0, 7'd0);
		set_base(64'd10);
		send(rod_pkg::REQ_LOOKUP, 64'd9, 12'd0, 7'd0);
		send(rod_pkg::REQ_RESIZE, 64'd0, 12'd10, 7'd0);
		send(rod_pkg::REQ_CHOP, 64'd3, 12'd0, 7'd2);
		send(rod_pkg::REQ_FIND, 64'd2, 12'd0, 7'd0);

		for (int p = 0; p < 6; p++) begin
			set_base(bases[p]);
			for (int n = 0; n < 300; n++) begin
				random_item(bases[p]);
			end
		end
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("sent %0d requests over %0d base settings, %0d responses checked",
			sent, phases, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("record_offset_directory_test: done, clean");
		else
			$display("record_offset_directory_test: done, errors");
		$finish;
	end

endmodule
